// ===== sv/mf2d_pkg.sv =====
// types and constants shared by the clipped 2-d median filter
// no dependencies
`default_nettype none
package mf2d_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GATHER,
		ST_DRAIN,
		ST_LOAD,
		ST_LATCH,
		ST_SCAN,
		ST_CHECK,
		ST_DECIDE,
		ST_OUT
	} state_t;

	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_FILTER = 1'b1;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	localparam logic [1:0] CFG_NUM_ROWS    = 2'd0;
	localparam logic [1:0] CFG_NUM_COLS    = 2'd1;
	localparam logic [1:0] CFG_HALF_WINDOW = 2'd2;

	typedef struct packed {
		logic        status;
		logic [5:0]  count;
		logic [31:0] median;
	} result_t;

endpackage
`default_nettype wire

// ===== sv/mf2d_ram.sv =====
// simple dual-port ram: one write port, one registered read port
// no dependencies
`default_nettype none
module mf2d_ram #(
	parameter int DW    = 32,
	parameter int AW    = 16,
	parameter int DEPTH = 65536
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== sv/median_filter_2d_clipped_unit.sv =====
// a write inside the image returns nothing; any request outside the image returns an error
// beat. a filter walks the clipped window into the window buffer, then tries each candidate
// in turn, scanning the window buffer against it, until one holds the lower median rank.
// one request in flight; ready only while idle. results wait in an output register.
// reset clears control state and config (256 rows, 256 cols, half-width 1);
// the pixel store is not cleared and holds garbage until written.
// depends on mf2d_pkg and mf2d_ram
`default_nettype none
module median_filter_2d_clipped_unit #(
	parameter int MAX_ROWS = 256,
	parameter int MAX_COLS = 256,
	parameter int MAX_HALF = 3
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [8:0]  cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // row[7:0], col[15:8], pixel_value[47:16]
	input  wire logic        s_tuser,   // req_type
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [39:0] m_tdata,   // median_value[31:0], window_count[37:32], zero pad
	output logic             m_tuser    // status
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int SAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int HCAP  = (MAX_HALF > 3) ? 3 : MAX_HALF;
	localparam int WD    = (2 * HCAP + 1) * (2 * HCAP + 1);
	localparam int WAW   = (WD > 1) ? $clog2(WD) : 1;

	mf2d_pkg::state_t state_q, state_d;

	logic [8:0] num_rows_q, num_cols_q;
	logic [1:0] half_q;

	logic [8:0] rows_eff, cols_eff;
	logic [2:0] h_eff;

	logic [7:0]  in_row, in_col;
	logic [31:0] in_pix;
	logic        accept, in_image;
	logic [8:0]  row_w, col_w, h9, rsum, csum;
	logic [7:0]  rmin, rmax, cmin, cmax;

	logic [7:0]  rmin_q, rmax_q, cmin_q, cmax_q;
	logic [7:0]  gr_q, gc_q;
	logic        gv_s1;
	logic [5:0]  n_q;
	logic [WAW-1:0] i_q, j_q;
	logic        sv_s1;
	logic [31:0] cand_q;
	logic [5:0]  less_q, leq_q, kth;
	logic        hit;
	logic [31:0] med_q;
	logic        err_q;

	logic           st_we;
	logic [SAW-1:0] st_waddr, st_raddr;
	logic [31:0]    st_rdata;
	logic [WAW-1:0] win_waddr, win_raddr;
	logic [31:0]    win_rdata;

	mf2d_pkg::result_t out_q;
	logic              m_tvalid_q;

	assign in_row = s_tdata[7:0];
	assign in_col = s_tdata[15:8];
	assign in_pix = s_tdata[47:16];

	assign rows_eff = (32'(num_rows_q) > MAX_ROWS) ? 9'(MAX_ROWS) : num_rows_q;
	assign cols_eff = (32'(num_cols_q) > MAX_COLS) ? 9'(MAX_COLS) : num_cols_q;
	assign h_eff    = (32'(half_q) > MAX_HALF) ? 3'(MAX_HALF) : {1'b0, half_q};

	assign s_tready = (state_q == mf2d_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	assign row_w    = {1'b0, in_row};
	assign col_w    = {1'b0, in_col};
	assign h9       = {6'd0, h_eff};
	assign in_image = (row_w < rows_eff) && (col_w < cols_eff);
	assign rsum     = row_w + h9;
	assign csum     = col_w + h9;
	assign rmin     = (row_w >= h9) ? 8'(row_w - h9) : 8'd0;
	assign cmin     = (col_w >= h9) ? 8'(col_w - h9) : 8'd0;
	// clip the far edge to the last row or column in use
	assign rmax     = (rsum > rows_eff - 9'd1) ? 8'(rows_eff - 9'd1) : 8'(rsum);
	assign cmax     = (csum > cols_eff - 9'd1) ? 8'(cols_eff - 9'd1) : 8'(csum);

	assign st_we    = accept && in_image && (s_tuser == mf2d_pkg::REQ_WRITE);
	assign st_waddr = SAW'(32'(in_row) * 32'(MAX_COLS) + 32'(in_col));
	assign st_raddr = SAW'(32'(gr_q) * 32'(MAX_COLS) + 32'(gc_q));

	mf2d_ram #(.DW(32), .AW(SAW), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (in_pix),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	assign win_waddr = WAW'(n_q);
	assign win_raddr = (state_q == mf2d_pkg::ST_SCAN) ? j_q : i_q;

	mf2d_ram #(.DW(32), .AW(WAW), .DEPTH(WD)) u_win (
		.clk   (clk),
		.we    (gv_s1),
		.waddr (win_waddr),
		.wdata (st_rdata),
		.raddr (win_raddr),
		.rdata (win_rdata)
	);

	// lower median rank
	assign kth = (n_q - 6'd1) >> 1;
	assign hit = (less_q <= kth) && (kth < leq_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mf2d_pkg::ST_IDLE: begin
				if (accept) begin
					if (!in_image) begin
						state_d = mf2d_pkg::ST_OUT;
					end else if (s_tuser == mf2d_pkg::REQ_FILTER) begin
						state_d = mf2d_pkg::ST_GATHER;
					end
				end
			end
			mf2d_pkg::ST_GATHER: begin
				if (gc_q == cmax_q && gr_q == rmax_q) begin
					state_d = mf2d_pkg::ST_DRAIN;
				end
			end
			mf2d_pkg::ST_DRAIN:  state_d = mf2d_pkg::ST_LOAD;
			mf2d_pkg::ST_LOAD:   state_d = mf2d_pkg::ST_LATCH;
			mf2d_pkg::ST_LATCH:  state_d = mf2d_pkg::ST_SCAN;
			mf2d_pkg::ST_SCAN: begin
				if (6'(j_q) == n_q - 6'd1) begin
					state_d = mf2d_pkg::ST_CHECK;
				end
			end
			mf2d_pkg::ST_CHECK:  state_d = mf2d_pkg::ST_DECIDE;
			mf2d_pkg::ST_DECIDE: begin
				state_d = hit ? mf2d_pkg::ST_OUT : mf2d_pkg::ST_LOAD;
			end
			mf2d_pkg::ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = mf2d_pkg::ST_IDLE;
				end
			end
			default: state_d = mf2d_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mf2d_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= 9'd256;
			num_cols_q <= 9'd256;
			half_q     <= 2'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mf2d_pkg::CFG_NUM_ROWS:    num_rows_q <= cfg_data;
				mf2d_pkg::CFG_NUM_COLS:    num_cols_q <= cfg_data;
				mf2d_pkg::CFG_HALF_WINDOW: half_q     <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gv_s1 <= 1'b0;
			sv_s1 <= 1'b0;
		end else begin
			gv_s1 <= (state_q == mf2d_pkg::ST_GATHER);
			sv_s1 <= (state_q == mf2d_pkg::ST_SCAN);
		end
	end

	// window walk, buffer fill and rank counting
	always_ff @(posedge clk) begin
		if (gv_s1) begin
			n_q <= n_q + 6'd1;
		end
		if (sv_s1) begin
			if ($signed(win_rdata) < $signed(cand_q)) begin
				less_q <= less_q + 6'd1;
			end
			if ($signed(win_rdata) <= $signed(cand_q)) begin
				leq_q <= leq_q + 6'd1;
			end
		end
		unique case (state_q)
			mf2d_pkg::ST_IDLE: begin
				rmin_q <= rmin;
				rmax_q <= rmax;
				cmin_q <= cmin;
				cmax_q <= cmax;
				gr_q   <= rmin;
				gc_q   <= cmin;
				n_q    <= 6'd0;
				i_q    <= '0;
				med_q  <= 32'd0;
				err_q  <= !in_image;
			end
			mf2d_pkg::ST_GATHER: begin
				if (gc_q == cmax_q) begin
					gc_q <= cmin_q;
					gr_q <= gr_q + 8'd1;
				end else begin
					gc_q <= gc_q + 8'd1;
				end
			end
			mf2d_pkg::ST_LATCH: begin
				cand_q <= win_rdata;
				j_q    <= '0;
				less_q <= 6'd0;
				leq_q  <= 6'd0;
			end
			mf2d_pkg::ST_SCAN: begin
				j_q <= j_q + WAW'(1);
			end
			mf2d_pkg::ST_DECIDE: begin
				med_q <= cand_q;
				i_q   <= i_q + WAW'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == mf2d_pkg::ST_OUT && (!m_tvalid_q || m_tready)) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mf2d_pkg::ST_OUT && (!m_tvalid_q || m_tready)) begin
			out_q.status <= err_q ? mf2d_pkg::STATUS_ERR : mf2d_pkg::STATUS_OK;
			out_q.count  <= n_q;
			out_q.median <= med_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, out_q.count, out_q.median};
	assign m_tuser  = out_q.status;

`ifndef SYNTH
	// an error beat carries zero median and zero count
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 40'd0)
		else $error("error beat with nonzero payload");

	// a good beat always has a nonempty window
	a_ok_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[37:32] != 6'd0)
		else $error("ok beat with empty window");

	// pixel writes only land while the sequencer is idle
	a_we_idle: assert property (@(posedge clk) disable iff (!arst_n)
		st_we |-> state_q == mf2d_pkg::ST_IDLE)
		else $error("store write outside idle");

	// compare data only arrives right after a scan read
	a_scan_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		sv_s1 |-> state_q == mf2d_pkg::ST_SCAN || state_q == mf2d_pkg::ST_CHECK)
		else $error("compare outside scan");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// testbench for median_filter_2d_clipped_unit: a directed table, then random phases under
// several image sizes and half-widths, each result checked against the table or the model
// depends on mf2d_pkg and the filter unit with its pixel store
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 40000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [8:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // row[7:0], col[15:8], pixel_value[47:16]
	logic        s_tuser;   // req_type
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;   // median_value[31:0], window_count[37:32], zero pad
	logic        m_tuser;   // status

	median_filter_2d_clipped_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// model of the block
	logic [31:0] image_mem [65536];
	bit          image_set [65536];
	logic [8:0]  img_rows, img_cols;
	logic [1:0]  img_half;
	mf2d_pkg::result_t pending_medians[$];

	int  errors = 0, results_seen = 0;
	int  filters_sent, calm;
	int  idle_cycles = 0;

	typedef struct {
		bit          is_cfg;
		logic        req;
		logic [7:0]  row;     // register index for config rows
		logic [7:0]  col;
		logic [31:0] pix;     // register data for config rows
		bit          typed;
		mf2d_pkg::result_t res;
	} step_t;

	step_t directed [] = '{
		'{0, mf2d_pkg::REQ_WRITE,  8'd0,   8'd0,   32'h8000_0000, 0, '0},
		'{0, mf2d_pkg::REQ_WRITE,  8'd0,   8'd1,   32'h7fff_ffff, 0, '0},
		'{0, mf2d_pkg::REQ_WRITE,  8'd1,   8'd0,   32'h0000_0000, 0, '0},
		'{0, mf2d_pkg::REQ_WRITE,  8'd1,   8'd1,   32'hffff_ffff, 0, '0},
		'{0, mf2d_pkg::REQ_FILTER, 8'd0,   8'd0,   32'h0,         1,
			'{mf2d_pkg::STATUS_OK, 6'd4, 32'hffff_ffff}},
		'{0, mf2d_pkg::REQ_WRITE,  8'd255, 8'd255, 32'h7fff_ffff, 0, '0},
		'{0, mf2d_pkg::REQ_WRITE,  8'd254, 8'd254, 32'h0000_0005, 0, '0},
		'{0, mf2d_pkg::REQ_WRITE,  8'd254, 8'd255, 32'h8000_0000, 0, '0},
		'{0, mf2d_pkg::REQ_WRITE,  8'd255, 8'd254, 32'h0000_0005, 0, '0},
		'{0, mf2d_pkg::REQ_FILTER, 8'd255, 8'd255, 32'hdead_beef, 1,
			'{mf2d_pkg::STATUS_OK, 6'd4, 32'h0000_0005}},
		'{1, mf2d_pkg::REQ_WRITE,  8'(mf2d_pkg::CFG_NUM_ROWS),    8'd0, 32'd4, 0, '0},
		'{1, mf2d_pkg::REQ_WRITE,  8'(mf2d_pkg::CFG_NUM_COLS),    8'd0, 32'd4, 0, '0},
		'{1, mf2d_pkg::REQ_WRITE,  8'(mf2d_pkg::CFG_HALF_WINDOW), 8'd0, 32'd0, 0, '0},
		'{0, mf2d_pkg::REQ_WRITE,  8'd4,   8'd0,   32'h1234_5678, 1,
			'{mf2d_pkg::STATUS_ERR, 6'd0, 32'h0}},
		'{0, mf2d_pkg::REQ_FILTER, 8'd0,   8'd4,   32'h0,         1,
			'{mf2d_pkg::STATUS_ERR, 6'd0, 32'h0}},
		'{0, mf2d_pkg::REQ_FILTER, 8'd1,   8'd1,   32'h0,         1,
			'{mf2d_pkg::STATUS_OK, 6'd1, 32'hffff_ffff}},
		'{0, mf2d_pkg::REQ_FILTER, 8'd255, 8'd255, 32'h0,         1,
			'{mf2d_pkg::STATUS_ERR, 6'd0, 32'h0}},
		'{1, mf2d_pkg::REQ_WRITE,  8'(mf2d_pkg::CFG_NUM_ROWS),    8'd0, 32'd0, 0, '0},
		'{0, mf2d_pkg::REQ_FILTER, 8'd0,   8'd0,   32'h0,         1,
			'{mf2d_pkg::STATUS_ERR, 6'd0, 32'h0}},
		'{0, mf2d_pkg::REQ_WRITE,  8'd0,   8'd0,   32'h0000_0001, 1,
			'{mf2d_pkg::STATUS_ERR, 6'd0, 32'h0}}
	};

	typedef struct {
		int rows, cols, half, items, no_idle;
	} phase_t;

	phase_t phases [] = '{
		'{256, 256, 1, 300, 0},
		'{8,   8,   0, 250, 1},
		'{1,   1,   3, 100, 0},
		'{0,   5,   2, 100, 0},
		'{511, 300, 3, 150, 0},
		'{13,  200, 2, 300, 0},
		'{256, 256, 3, 150, 0},
		'{3,   256, 2, 400, 0}
	};

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int eff(input int v, input int lim);
		return (v > lim) ? lim : v;
	endfunction

	// clipped window bounds under the current settings
	function automatic void window_bounds(input int row, input int col,
	                                      output int r0, output int r1,
	                                      output int c0, output int c1);
		int rows, cols, h;
		rows = eff(img_rows, 256);
		cols = eff(img_cols, 256);
		h = eff(img_half, 3);
		r0 = (row >= h) ? row - h : 0;
		r1 = (row + h > rows - 1) ? rows - 1 : row + h;
		c0 = (col >= h) ? col - h : 0;
		c1 = (col + h > cols - 1) ? cols - 1 : col + h;
	endfunction

	function automatic bit is_inside(input int row, input int col);
		return row < eff(img_rows, 256) && col < eff(img_cols, 256);
	endfunction

	// address of a window pixel never written, or -1
	function automatic int first_unset(input int row, input int col);
		int r0, r1, c0, c1;
		window_bounds(row, col, r0, r1, c0, c1);
		for (int r = r0; r <= r1; r++)
			for (int c = c0; c <= c1; c++)
				if (!image_set[r * 256 + c]) return r * 256 + c;
		return -1;
	endfunction

	// updates the image and returns 1 with the result where one is due
	function automatic bit predict_median(input logic req, input int row, input int col,
	                                      input logic [31:0] pix,
	                                      output mf2d_pkg::result_t res);
		logic signed [31:0] win [$];
		logic signed [31:0] t;
		int r0, r1, c0, c1, j;
		res = '0;
		if (!is_inside(row, col)) begin
			res.status = mf2d_pkg::STATUS_ERR;
			return 1;
		end
		if (req == mf2d_pkg::REQ_WRITE) begin
			image_mem[row * 256 + col] = pix;
			image_set[row * 256 + col] = 1'b1;
			return 0;
		end
		window_bounds(row, col, r0, r1, c0, c1);
		for (int r = r0; r <= r1; r++)
			for (int c = c0; c <= c1; c++)
				win.insert(win.size(), image_mem[r * 256 + c]);
		for (int i = 1; i < win.size(); i++) begin
			t = win[i];
			j = i - 1;
			while (j >= 0 && win[j] > t) begin
				win[j + 1] = win[j];
				j--;
			end
			win[j + 1] = t;
		end
		res.status = mf2d_pkg::STATUS_OK;
		res.count = 6'(win.size());
		res.median = win[(win.size() - 1) / 2];
		return 1;
	endfunction

	task automatic send_req(input logic req, input logic [7:0] row, input logic [7:0] col,
	                        input logic [31:0] pix, input bit typed,
	                        input mf2d_pkg::result_t typed_res);
		mf2d_pkg::result_t res;
		@(negedge clk);
		if (!calm && $urandom_range(99) < 24) begin
			s_tvalid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < 24);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {pix, col, row};
		do @(posedge clk); while (!s_tready);
		if (predict_median(req, row, col, pix, res))
			pending_medians.insert(pending_medians.size(), typed ? typed_res : res);
		if (req == mf2d_pkg::REQ_FILTER) filters_sent++;
	endtask

	// register writes only with the block idle and nothing outstanding
	task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_medians.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		unique case (idx)
			mf2d_pkg::CFG_NUM_ROWS:    img_rows = val;
			mf2d_pkg::CFG_NUM_COLS:    img_cols = val;
			mf2d_pkg::CFG_HALF_WINDOW: img_half = val[1:0];
			default: ;
		endcase
	endtask

	function automatic logic [31:0] rand_pixel();
		unique case ($urandom_range(3))
			0: return 32'h8000_0000 | ($urandom_range(1) ? 32'h7fff_ffff : 32'h0);
			1: return 32'($urandom_range(4)) - 32'd2;
			default: return $urandom;
		endcase
	endfunction

	// centre near an edge of the image most of the time, anywhere otherwise
	function automatic int rand_coord(input int lim);
		int v;
		if (lim <= 0 || $urandom_range(99) < 20) return $urandom_range(255);
		v = $urandom_range(1) ? $urandom_range(7) : lim - 1 - $urandom_range(7);
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return v;
	endfunction

	// output side: random back-pressure and result checking
	always @(negedge clk)
		m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 24);

	always @(posedge clk) begin
		mf2d_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_medians.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat median=%h count=%0d status=%0d",
				         $realtime, m_tdata[31:0], m_tdata[37:32], m_tuser);
			end else begin
				want = pending_medians.pop_front();
				if (m_tdata[31:0] !== want.median || m_tdata[37:32] !== want.count ||
				    m_tuser !== want.status) begin
					errors++;
					$display("%0t: expected med=%h cnt=%0d st=%0d, got med=%h cnt=%0d st=%0d",
					         $realtime, want.median, want.count, want.status,
					         m_tdata[31:0], m_tdata[37:32], m_tuser);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog, no beat for %0d cycles", $realtime, idle_cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int row, col, miss;
		logic req;
		filters_sent = 0;
		calm = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = mf2d_pkg::REQ_WRITE;
		img_rows = 9'd256;
		img_cols = 9'd256;
		img_half = 2'd1;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i]) begin
			if (directed[i].is_cfg)
				write_reg(directed[i].row[1:0], directed[i].pix[8:0]);
			else
				send_req(directed[i].req, directed[i].row, directed[i].col,
				         directed[i].pix, directed[i].typed, directed[i].res);
		end

		foreach (phases[p]) begin
			write_reg(mf2d_pkg::CFG_NUM_ROWS, 9'(phases[p].rows));
			write_reg(mf2d_pkg::CFG_NUM_COLS, 9'(phases[p].cols));
			write_reg(mf2d_pkg::CFG_HALF_WINDOW, 9'(phases[p].half));
			calm = phases[p].no_idle;
			for (int k = 0; k < phases[p].items; k++) begin
				row = rand_coord(eff(img_rows, 256));
				col = rand_coord(eff(img_cols, 256));
				req = ($urandom_range(99) < 45) ? mf2d_pkg::REQ_FILTER : mf2d_pkg::REQ_WRITE;
				if (req == mf2d_pkg::REQ_FILTER && is_inside(row, col)) begin
					// fill the window first so no unwritten pixel is ever read
					miss = first_unset(row, col);
					if (miss >= 0) begin
						req = mf2d_pkg::REQ_WRITE;
						row = miss / 256;
						col = miss % 256;
					end
				end
				send_req(req, 8'(row), 8'(col), rand_pixel(), 0, '0);
			end
			calm = 0;
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_medians.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("run covered %0d directed steps and %0d random phases", directed.size(),
		         phases.size());
		$display("%0d filter requests, %0d result beats checked", filters_sent, results_seen);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
`default_nettype wire
